[src/sbrm_pkg.sv]
`default_nettype none

package sbrm_pkg;

   // Operation carried by each input item
   typedef enum logic [2:0] {
      MODE_RIOT_READ  = 3'd0,
      MODE_RIOT_WRITE = 3'd1,
      MODE_CMD_READ   = 3'd2,
      MODE_REPLY_WR   = 3'd3,
      MODE_MAIN_CMD   = 3'd4,
      MODE_TICK       = 3'd5
   } mode_type;

   // RIOT register offsets within the window
   localparam logic [4:0] REG_PORT_A     = 5'd0;
   localparam logic [4:0] REG_PORT_A_DIR = 5'd1;
   localparam logic [4:0] REG_PORT_B     = 5'd2;
   localparam logic [4:0] REG_PORT_B_DIR = 5'd3;
   localparam logic [4:0] REG_IRQ_FLAGS  = 5'd5;
   localparam logic [4:0] REG_PA7_ENABLE = 5'd7;
   localparam logic [4:0] REG_TIMER      = 5'd31;

   // Port A bit constants
   localparam logic [7:0] PA_READ_FORCE  = 8'h10;
   localparam logic [7:0] PA_SPEECH_BUSY = 8'h04;
   localparam logic [7:0] PA_CMD_PENDING = 8'h80;
   localparam logic [7:0] PA_CMD_CLEAR   = 8'h7f;
   localparam logic [7:0] PA_REPLY_FULL  = 8'h40;
   localparam logic [7:0] IRQ_TIMER_FLAG = 8'h80;
   localparam logic [7:0] CMD_IGNORE     = 8'hff;
   localparam logic [7:0] CMD_SPEECH_ON  = 8'h00;

   localparam int TIMER_W = 18;

   typedef struct packed {
      logic       speech_ready;
      logic [7:0] write_data;
      logic [4:0] register_offset;
      mode_type   mode;
   } req_item_type;

   typedef struct packed {
      logic [7:0] reply_byte;
      logic       cpu_irq;
      logic [7:0] speech_byte;
      logic       speech_strobe;
      logic [7:0] read_data;
   } rsp_item_type;

endpackage

`default_nettype wire

[src/sound_board_riot_mailbox_unit.sv]
// 6532-style I/O block of a sound board with its main/sound command mailboxes.
// Each request item is one bus access or timer tick (kind in req_tuser) and
// yields exactly one response item with read data, speech strobe and byte,
// interrupt pulse and the current reply latch. Items pass an input register,
// combinational decode and state update, and a response register; one item
// is taken every cycle as long as rsp_tready keeps up. The timer counts
// ticks, write_data * TIMER_PRESCALE of them, in an 18-bit counter.
`default_nettype none

module sound_board_riot_mailbox_unit
   import sbrm_pkg::*;
#(
   parameter int TIMER_PRESCALE = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [2:0]  req_tuser,   // [2:0] mode
   input  wire logic [15:0] req_tdata,   // [4:0] register_offset, [12:5] write_data,
                                         // [13] speech_ready, [15:14] zero
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [7:0] read_data, [8] speech_strobe,
                                         // [16:9] speech_byte, [17] cpu_irq,
                                         // [25:18] reply_byte, [31:26] zero
);

   logic         in_valid_ff;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type core_result;
   logic         advance;

   // Unpack the request
   assign in_item_in.mode            = mode_type'(req_tuser);
   assign in_item_in.register_offset = req_tdata[4:0];
   assign in_item_in.write_data      = req_tdata[12:5];
   assign in_item_in.speech_ready    = req_tdata[13];

   // Item in the input register retires when the response register is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= in_item_in;
      end
   end

   sbrm_core #(
      .TIMER_PRESCALE(TIMER_PRESCALE)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (in_item_ff),
      .result(core_result)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_item_ff};

   // A retired item always shows up in the response register
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("retired item did not reach response register");

   // A held item in the input register keeps its contents
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("stalled input item lost or changed");

   // Speech strobe and interrupt come from different operations
   a_strobe_irq_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_item_ff.speech_strobe && out_item_ff.cpu_irq))
      else $error("speech strobe and irq in the same item");

   // An empty input register always accepts
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("empty input register not ready");

endmodule

`default_nettype wire

[src/sbrm_core.sv]
`default_nettype none

module sbrm_core
   import sbrm_pkg::*;
#(
   parameter int TIMER_PRESCALE = 1024
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         fire,
   input  wire req_item_type item,
   output rsp_item_type      result
);

   localparam logic [TIMER_W-1:0] PRESCALE = TIMER_W'(TIMER_PRESCALE);

   logic [7:0]         port_a_ff, port_a_in;
   logic [7:0]         port_a_dir_ff, port_a_dir_in;
   logic [7:0]         port_b_ff, port_b_in;
   logic [7:0]         port_b_dir_ff, port_b_dir_in;
   logic [7:0]         irq_flags_ff, irq_flags_in;
   logic               pa7_en_ff, pa7_en_in;
   logic [7:0]         cmd_latch_ff, cmd_latch_in;
   logic [7:0]         reply_latch_ff, reply_latch_in;
   logic               speech_en_ff, speech_en_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic               armed_ff, armed_in;
   logic [7:0]         pa_merged;
   logic [TIMER_W-1:0] timer_load;

   // Port A merge under the direction mask
   assign pa_merged  = (port_a_ff & ~port_a_dir_ff) | (item.write_data & port_a_dir_ff);
   // Timer load value: byte times prescale, kept to the counter width
   assign timer_load = TIMER_W'(item.write_data) * PRESCALE;

   // Next state and result for the current item
   always_comb begin
      port_a_in      = port_a_ff;
      port_a_dir_in  = port_a_dir_ff;
      port_b_in      = port_b_ff;
      port_b_dir_in  = port_b_dir_ff;
      irq_flags_in   = irq_flags_ff;
      pa7_en_in      = pa7_en_ff;
      cmd_latch_in   = cmd_latch_ff;
      reply_latch_in = reply_latch_ff;
      speech_en_in   = speech_en_ff;
      timer_in       = timer_ff;
      armed_in       = armed_ff;
      result         = '0;

      case (item.mode)
         MODE_RIOT_READ: begin
            case (item.register_offset)
               REG_PORT_A: begin
                  result.read_data = port_a_ff | PA_READ_FORCE |
                                     (item.speech_ready ? 8'h00 : PA_SPEECH_BUSY);
               end
               REG_PORT_A_DIR: result.read_data = port_a_dir_ff;
               REG_PORT_B:     result.read_data = port_b_ff;
               REG_PORT_B_DIR: result.read_data = port_b_dir_ff;
               REG_IRQ_FLAGS: begin
                  result.read_data = irq_flags_ff;
                  irq_flags_in     = '0;
               end
               default: ;
            endcase
         end
         MODE_RIOT_WRITE: begin
            case (item.register_offset)
               REG_PORT_A: begin
                  port_a_in = pa_merged;
                  // falling edge on PA0 latches port B into the speech chip
                  if (port_a_ff[0] && !pa_merged[0] && speech_en_ff) begin
                     result.speech_strobe = 1'b1;
                     result.speech_byte   = port_b_ff;
                  end
               end
               REG_PORT_A_DIR: port_a_dir_in = item.write_data;
               REG_PORT_B:     port_b_in     = item.write_data;
               REG_PORT_B_DIR: port_b_dir_in = item.write_data;
               REG_PA7_ENABLE: pa7_en_in     = (item.write_data != 8'h00);
               REG_TIMER: begin
                  timer_in = timer_load;
                  armed_in = 1'b1;
               end
               default: ;
            endcase
         end
         MODE_CMD_READ: begin
            port_a_in        = port_a_ff & PA_CMD_CLEAR;
            result.read_data = cmd_latch_ff;
            cmd_latch_in     = '0;
         end
         MODE_REPLY_WR: begin
            port_a_in      = port_a_ff | PA_REPLY_FULL;
            reply_latch_in = item.write_data;
         end
         MODE_MAIN_CMD: begin
            if (item.write_data != CMD_IGNORE) begin
               if (item.write_data == CMD_SPEECH_ON) begin
                  speech_en_in = 1'b1;
               end
               port_a_in      = port_a_ff | PA_CMD_PENDING;
               cmd_latch_in   = item.write_data;
               result.cpu_irq = pa7_en_ff;
            end
         end
         MODE_TICK: begin
            if (armed_ff) begin
               if (timer_ff <= TIMER_W'(1)) begin
                  timer_in       = '0;
                  armed_in       = 1'b0;
                  irq_flags_in   = irq_flags_ff | IRQ_TIMER_FLAG;
                  result.cpu_irq = 1'b1;
               end else begin
                  timer_in = timer_ff - TIMER_W'(1);
               end
            end
         end
         default: ;
      endcase

      result.reply_byte = reply_latch_in;
   end

   // State update when the item is retired
   always_ff @(posedge clock) begin
      if (reset) begin
         port_a_ff      <= '0;
         port_a_dir_ff  <= '0;
         port_b_ff      <= '0;
         port_b_dir_ff  <= '0;
         irq_flags_ff   <= '0;
         pa7_en_ff      <= 1'b0;
         cmd_latch_ff   <= '0;
         reply_latch_ff <= '0;
         speech_en_ff   <= 1'b0;
         timer_ff       <= '0;
         armed_ff       <= 1'b0;
      end else if (fire) begin
         port_a_ff      <= port_a_in;
         port_a_dir_ff  <= port_a_dir_in;
         port_b_ff      <= port_b_in;
         port_b_dir_ff  <= port_b_dir_in;
         irq_flags_ff   <= irq_flags_in;
         pa7_en_ff      <= pa7_en_in;
         cmd_latch_ff   <= cmd_latch_in;
         reply_latch_ff <= reply_latch_in;
         speech_en_ff   <= speech_en_in;
         timer_ff       <= timer_in;
         armed_ff       <= armed_in;
      end
   end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sbrm_pkg::*;

   localparam int PRESCALE     = 1024;
   localparam int RANDOM_ITEMS = 1850;

   // Riot offset with no register behind it, and the two spare modes
   localparam logic [4:0] REG_UNUSED    = 5'd4;
   localparam logic [2:0] MODE_SPARE_LO = 3'd6;
   localparam logic [2:0] MODE_SPARE_HI = 3'd7;

   // One queued bus access or tick; hold marks a pause until all results are back
   typedef struct packed {
      logic       hold;
      logic [2:0] mode;
      logic [4:0] offset;
      logic [7:0] data;
      logic       ready;
   } bus_op_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser  = '0;   // [2:0] mode
   logic [15:0] req_tdata  = '0;   // [4:0] offset, [12:5] write_data, [13] speech_ready
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [7:0] read_data, [8] strobe, [16:9] speech_byte,
                                   // [17] cpu_irq, [25:18] reply_byte

   bus_op_type   pending_accesses[$];
   rsp_item_type due_results[$];

   int unsigned err_count    = 0;
   int unsigned queued_count = 0;
   int unsigned rsp_count    = 0;
   int unsigned strobe_count = 0;
   int unsigned irq_count    = 0;

   // Driver and monitor pacing
   int unsigned send_wait  = 0;
   bit          send_calm  = 1'b0;
   bit          draining   = 1'b0;
   int unsigned recv_stall = 0;
   bit          recv_calm  = 1'b0;

   // Shadow copy of the block's state
   logic [7:0]  pa_val      = '0;
   logic [7:0]  pa_dir      = '0;
   logic [7:0]  pb_val      = '0;
   logic [7:0]  pb_dir      = '0;
   logic [7:0]  irq_flags   = '0;
   logic [7:0]  cmd_latch   = '0;
   logic [7:0]  reply_latch = '0;
   logic        pa7_en      = 1'b0;
   logic        speech_on   = 1'b0;
   logic        tmr_armed   = 1'b0;
   logic [17:0] tmr_count   = '0;

   sound_board_riot_mailbox_unit #(
      .TIMER_PRESCALE(PRESCALE)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Apply one access to the shadow state and return the result it produces
   function automatic rsp_item_type riot_mailbox_step(bus_op_type op);
      rsp_item_type r;
      logic         pa0_was_high;
      r = '0;
      case (op.mode)
         MODE_RIOT_READ: begin
            case (op.offset)
               REG_PORT_A:
                  r.read_data = pa_val | PA_READ_FORCE | (op.ready ? 8'h00 : PA_SPEECH_BUSY);
               REG_PORT_A_DIR: r.read_data = pa_dir;
               REG_PORT_B:     r.read_data = pb_val;
               REG_PORT_B_DIR: r.read_data = pb_dir;
               REG_IRQ_FLAGS: begin
                  r.read_data = irq_flags;
                  irq_flags   = '0;
               end
               default: ;
            endcase
         end
         MODE_RIOT_WRITE: begin
            case (op.offset)
               REG_PORT_A: begin
                  pa0_was_high = pa_val[0];
                  pa_val = (pa_val & ~pa_dir) | (op.data & pa_dir);
                  // falling PA0 pushes port B out to the speech chip
                  if (pa0_was_high && !pa_val[0] && speech_on) begin
                     r.speech_strobe = 1'b1;
                     r.speech_byte   = pb_val;
                  end
               end
               REG_PORT_A_DIR: pa_dir = op.data;
               REG_PORT_B:     pb_val = op.data;
               REG_PORT_B_DIR: pb_dir = op.data;
               REG_PA7_ENABLE: pa7_en = (op.data != 8'h00);
               REG_TIMER: begin
                  tmr_count = 18'(int'(op.data) * PRESCALE);
                  tmr_armed = 1'b1;
               end
               default: ;
            endcase
         end
         MODE_CMD_READ: begin
            pa_val      = pa_val & PA_CMD_CLEAR;
            r.read_data = cmd_latch;
            cmd_latch   = '0;
         end
         MODE_REPLY_WR: begin
            pa_val      = pa_val | PA_REPLY_FULL;
            reply_latch = op.data;
         end
         MODE_MAIN_CMD: begin
            if (op.data != CMD_IGNORE) begin
               if (op.data == CMD_SPEECH_ON)
                  speech_on = 1'b1;
               pa_val    = pa_val | PA_CMD_PENDING;
               cmd_latch = op.data;
               r.cpu_irq = pa7_en;
            end
         end
         MODE_TICK: begin
            if (tmr_armed) begin
               if (tmr_count <= 18'd1) begin
                  tmr_count = '0;
                  tmr_armed = 1'b0;
                  irq_flags = irq_flags | IRQ_TIMER_FLAG;
                  r.cpu_irq = 1'b1;
               end else begin
                  tmr_count = tmr_count - 18'd1;
               end
            end
         end
         default: ;
      endcase
      r.reply_byte = reply_latch;
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         err_count++;
         $error("%s: expected %02h, got %02h", name, want, got);
      end
   endfunction

   // Driver: feeds queued items, random gap after each, pauses on hold markers
   always @(posedge clock) begin
      bus_op_type op;
      if (!reset && (!req_tvalid || req_tready)) begin
         if (send_wait != 0) begin
            req_tvalid <= 1'b0;
            send_wait--;
         end else if (draining) begin
            req_tvalid <= 1'b0;
            if (due_results.size() == 0)
               draining = 1'b0;
         end else if (pending_accesses.size() == 0) begin
            req_tvalid <= 1'b0;
         end else begin
            op = pending_accesses.pop_front();
            if (op.hold) begin
               req_tvalid <= 1'b0;
               draining = 1'b1;
            end else begin
               req_tvalid <= 1'b1;
               req_tuser  <= op.mode;
               req_tdata  <= {2'b00, op.ready, op.data, op.offset};
               send_wait = send_calm ? 0 : $urandom_range(0, 7);
               if ($urandom_range(0, 63) == 0)
                  send_calm = !send_calm;
            end
         end
      end
   end

   // Monitor: checks results in order, predicts from accepted requests
   always @(posedge clock) begin
      rsp_item_type got, want;
      bus_op_type   seen;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_item_type'(rsp_tdata[25:0]);
            rsp_count++;
            strobe_count += got.speech_strobe;
            irq_count    += got.cpu_irq;
            if (due_results.size() == 0) begin
               err_count++;
               $error("result %h arrived with none expected", rsp_tdata);
            end else begin
               want = due_results.pop_front();
               check_field("read_data", want.read_data, got.read_data);
               check_field("speech_strobe", want.speech_strobe, got.speech_strobe);
               check_field("speech_byte", want.speech_byte, got.speech_byte);
               check_field("cpu_irq", want.cpu_irq, got.cpu_irq);
               check_field("reply_byte", want.reply_byte, got.reply_byte);
            end
            recv_stall = recv_calm ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 63) == 0)
               recv_calm = !recv_calm;
         end
         if (req_tvalid && req_tready) begin
            seen        = '0;
            seen.mode   = req_tuser;
            seen.offset = req_tdata[4:0];
            seen.data   = req_tdata[12:5];
            seen.ready  = req_tdata[13];
            due_results.push_back(riot_mailbox_step(seen));
         end
         if (recv_stall != 0) begin
            rsp_tready <= 1'b0;
            recv_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus helpers
   task automatic put(logic [2:0] mode, logic [4:0] offset, logic [7:0] data, logic ready);
      bus_op_type op;
      op        = '0;
      op.mode   = mode;
      op.offset = offset;
      op.data   = data;
      op.ready  = ready;
      pending_accesses.push_back(op);
      queued_count++;
   endtask

   task automatic put_hold();
      bus_op_type op;
      op      = '0;
      op.hold = 1'b1;
      pending_accesses.push_back(op);
   endtask

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [4:0] pick_offset();
      case ($urandom_range(0, 9))
         0:       return REG_PORT_A;
         1:       return REG_PORT_A_DIR;
         2:       return REG_PORT_B;
         3:       return REG_PORT_B_DIR;
         4:       return REG_IRQ_FLAGS;
         5:       return REG_PA7_ENABLE;
         6:       return REG_TIMER;
         default: return 5'($urandom);
      endcase
   endfunction

   // Any single access; timer starts and ticks left out when a countdown runs
   task automatic put_noise(bit allow_timer);
      logic [2:0] m;
      logic [4:0] o;
      m = 3'($urandom_range(0, 5));
      if ($urandom_range(0, 40) == 0)
         m = $urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI;
      o = pick_offset();
      if (!allow_timer && (m == MODE_TICK || (m == MODE_RIOT_WRITE && o == REG_TIMER)))
         m = MODE_RIOT_READ;
      put(m, o, rand_byte(), 1'($urandom));
   endtask

   // Set up PA0 high, load port B, then drop PA0
   task automatic put_speech_seq();
      if ($urandom_range(0, 3) == 0)
         put(MODE_MAIN_CMD, pick_offset(), CMD_SPEECH_ON, 1'($urandom));
      put(MODE_RIOT_WRITE, REG_PORT_A_DIR, rand_byte() | 8'h01, 1'($urandom));
      put(MODE_RIOT_WRITE, REG_PORT_A, rand_byte() | 8'h01, 1'($urandom));
      put(MODE_RIOT_WRITE, REG_PORT_B, rand_byte(), 1'($urandom));
      if ($urandom_range(0, 1))
         put_noise(1'b1);
      put(MODE_RIOT_WRITE, REG_PORT_A, rand_byte() & 8'hfe, 1'($urandom));
      put(MODE_RIOT_READ, REG_PORT_A, rand_byte(), 1'($urandom));
   endtask

   // Short timer run: optional long start, restart at zero, a few ticks
   task automatic put_timer_seq();
      if ($urandom_range(0, 1))
         put(MODE_RIOT_WRITE, REG_TIMER, rand_byte(), 1'($urandom));
      put(MODE_RIOT_WRITE, REG_TIMER, 8'h00, 1'($urandom));
      repeat ($urandom_range(1, 4)) begin
         put(MODE_TICK, 5'($urandom), rand_byte(), 1'($urandom));
         if ($urandom_range(0, 2) == 0)
            put_noise(1'b0);
      end
      put(MODE_RIOT_READ, REG_IRQ_FLAGS, rand_byte(), 1'($urandom));
   endtask

   // Main command, then the sound side picks it up and replies
   task automatic put_mailbox_seq();
      logic [7:0] cmd;
      if ($urandom_range(0, 2) == 0)
         put(MODE_RIOT_WRITE, REG_PA7_ENABLE, $urandom_range(0, 1) ? 8'h00 : rand_byte(),
             1'($urandom));
      case ($urandom_range(0, 5))
         0:       cmd = CMD_IGNORE;
         1:       cmd = CMD_SPEECH_ON;
         default: cmd = rand_byte();
      endcase
      put(MODE_MAIN_CMD, 5'($urandom), cmd, 1'($urandom));
      if ($urandom_range(0, 1))
         put(MODE_RIOT_READ, REG_PORT_A, rand_byte(), 1'($urandom));
      put(MODE_CMD_READ, 5'($urandom), rand_byte(), 1'($urandom));
      put(MODE_REPLY_WR, 5'($urandom), rand_byte(), 1'($urandom));
      put(MODE_RIOT_READ, REG_PORT_A, rand_byte(), 1'($urandom));
   endtask

   // Full prescaled count: start at one, expire on tick number PRESCALE
   task automatic put_long_countdown();
      int ticks;
      ticks = 0;
      put(MODE_RIOT_WRITE, REG_TIMER, 8'h01, 1'($urandom));
      while (ticks < PRESCALE - 1) begin
         if ($urandom_range(0, 4) != 0) begin
            put(MODE_TICK, 5'($urandom), rand_byte(), 1'($urandom));
            ticks++;
         end else begin
            put_noise(1'b0);
         end
      end
      put(MODE_RIOT_READ, REG_IRQ_FLAGS, 8'h00, 1'b1);
      put(MODE_TICK, REG_PORT_A, 8'h00, 1'b0);
      put(MODE_RIOT_READ, REG_IRQ_FLAGS, 8'h00, 1'b1);
   endtask

   initial begin
      int unsigned directed_end;
      bit          long_done;

      // Directed: reset values, speech edge both ways, mailboxes, timer, spare codes
      put(MODE_RIOT_READ, REG_PORT_A, 8'h00, 1'b0);
      put(MODE_RIOT_READ, REG_PORT_A, 8'hff, 1'b1);
      put(MODE_RIOT_WRITE, REG_PORT_A_DIR, 8'hff, 1'b1);
      put(MODE_RIOT_WRITE, REG_PORT_A, 8'hff, 1'b1);
      put(MODE_RIOT_WRITE, REG_PORT_A, 8'h00, 1'b1);   // edge, speech still off
      put(MODE_RIOT_WRITE, REG_PORT_A, 8'hff, 1'b1);
      put(MODE_MAIN_CMD, REG_PORT_A, CMD_SPEECH_ON, 1'b1);
      put(MODE_RIOT_WRITE, REG_PORT_B, 8'ha5, 1'b1);
      put(MODE_RIOT_WRITE, REG_PORT_A, 8'h00, 1'b0);   // edge with speech on
      put(MODE_RIOT_WRITE, REG_PORT_B_DIR, 8'h5a, 1'b0);
      put(MODE_RIOT_READ, REG_PORT_A_DIR, 8'h00, 1'b1);
      put(MODE_RIOT_READ, REG_PORT_B, 8'h00, 1'b1);
      put(MODE_RIOT_READ, REG_PORT_B_DIR, 8'h00, 1'b1);
      put(MODE_RIOT_WRITE, REG_PA7_ENABLE, 8'h01, 1'b1);
      put(MODE_MAIN_CMD, 5'h1f, CMD_IGNORE, 1'b1);
      put(MODE_MAIN_CMD, REG_PORT_A, 8'h80, 1'b1);
      put(MODE_CMD_READ, REG_PORT_A, 8'h00, 1'b1);
      put(MODE_REPLY_WR, REG_PORT_A, 8'hff, 1'b1);
      put(MODE_RIOT_WRITE, REG_TIMER, 8'hff, 1'b1);
      put(MODE_RIOT_WRITE, REG_TIMER, 8'h00, 1'b1);    // restart reloads
      put(MODE_TICK, REG_PORT_A, 8'h00, 1'b1);
      put(MODE_TICK, REG_PORT_A, 8'h00, 1'b1);         // disarmed: no effect
      put(MODE_RIOT_READ, REG_IRQ_FLAGS, 8'h00, 1'b1);
      put(MODE_RIOT_READ, REG_IRQ_FLAGS, 8'h00, 1'b1); // cleared by the read
      put(MODE_RIOT_WRITE, REG_UNUSED, 8'hff, 1'b1);
      put(MODE_RIOT_READ, REG_UNUSED, 8'hff, 1'b1);
      put(MODE_RIOT_READ, REG_TIMER, 8'h00, 1'b1);
      put(MODE_SPARE_LO, 5'h1f, 8'hff, 1'b1);
      put(MODE_SPARE_HI, 5'h1f, 8'hff, 1'b0);
      put(MODE_RIOT_WRITE, REG_PA7_ENABLE, 8'h00, 1'b1);
      put_hold();
      directed_end = queued_count;

      // Random: mostly well-formed sequences, some noise, one full countdown
      long_done = 1'b0;
      while (queued_count < directed_end + RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2: repeat ($urandom_range(1, 6)) put_noise(1'b1);
            3, 4:    put_speech_seq();
            5, 6:    put_timer_seq();
            default: put_mailbox_seq();
         endcase
         if (!long_done && queued_count > directed_end + 200) begin
            put_long_countdown();
            long_done = 1'b1;
         end
         if ($urandom_range(0, 49) == 0)
            put_hold();
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_accesses.size() != 0 || req_tvalid || draining || due_results.size() != 0);
      repeat (8) @(negedge clock);

      $display("tb_top: %0d accesses and ticks checked, %0d speech strobes, %0d cpu interrupts",
               rsp_count, strobe_count, irq_count);
      if (err_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

   // Watchdog
   initial begin
      #5ms;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
